// ===== hw/rtl/psms_pkg.sv =====
// Shared widths, command codes and the stored sphere record for the periodic
// sphere membership search. No dependencies; imported by the top level.

package psms_pkg;

    localparam int POS_W          = 23;
    localparam int MASS_W         = 32;
    localparam int INDEX_W        = 10;
    localparam int CMD_W          = 2;
    localparam int IN_TDATA_W     = 128;
    localparam int OUT_TDATA_W    = 48;
    localparam int OUT_TUSER_W    = 2;
    localparam int SQ_W           = 2 * POS_W;
    localparam int ACC_W          = SQ_W + 2;

    localparam int DEF_MAX_SPHERES = 1024;

    localparam logic [POS_W-1:0] BOX_RESET = 23'd7864320;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // One stored sphere; x sits in the lowest bits, as on the input word.
    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic [POS_W-1:0]  radius;
        logic [POS_W-1:0]  z;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  x;
    } sphere_t;

    localparam int SPHERE_W = $bits(sphere_t);

endpackage

// ===== hw/rtl/periodic_sphere_membership_search.sv =====
// Top level of the periodic sphere membership search: sphere table, scan
// sequencer with one shared multiplier, and the result register.
// Depends on psms_pkg.

// The block holds a table of up to MAX_SPHERES spheres and answers point queries
// against it in a periodic cube whose edge is the box_length register.
// Input words arrive on the s_ channel; s_tuser carries the command (clear,
// append, query) and s_tdata the point or sphere. Every input word yields exactly
// one output word on the m_ channel: found and status on m_tuser, the matching
// index and mass on m_tdata. The cfg channel loads box_length and is always ready.
// Clear, append and unused commands answer directly: the result is registered
// at the edge that accepts the word. A query visits the table in load order, one
// sphere at a time, and for each sphere it does one memory read, then for
// each of x, y and z a difference, a wrap to the minimum image, a square and an
// accumulate, then the squared radius and the compare, all through one shared
// 23 by 23 bit multiplier. A query that matches sphere j answers once sphere j
// is checked; a miss answers once every stored sphere is checked.
// The block takes one word at a time: s_tready is high only while the sequencer
// is idle and the output register is empty or being emptied. When the receiver
// stalls, the result waits in the output register and no new word is taken.
// Reset empties the table (count zero), loads box_length with 120.0, and drops
// m_tvalid. The table memory itself is not cleared; entries are read only below
// the fill count.

module periodic_sphere_membership_search #(
    parameter int MAX_SPHERES = psms_pkg::DEF_MAX_SPHERES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write: box_length.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psms_pkg::POS_W-1:0]         cfg_data,
    // Input words.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From bit 0 up: pos_x[22:0], pos_y[45:23], pos_z[68:46], radius[91:69],
    // mass_tag[123:92], zero padding[127:124].
    input  logic [psms_pkg::IN_TDATA_W-1:0]    s_tdata,
    // cmd[1:0].
    input  logic [psms_pkg::CMD_W-1:0]         s_tuser,
    // Output words.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From bit 0 up: match_index[9:0], match_mass[41:10], zero padding[47:42].
    output logic [psms_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // From bit 0 up: found[0], status[1].
    output logic [psms_pkg::OUT_TUSER_W-1:0]   m_tuser
);

    import psms_pkg::*;

    localparam int IDX_W  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W  = $clog2(MAX_SPHERES + 1);
    localparam int OUT_PAD_W = OUT_TDATA_W - MASS_W - INDEX_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_WRAP = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;

    // Step codes inside one sphere: three axes, then the radius.
    localparam logic [1:0] STEP_X = 2'd0;
    localparam logic [1:0] STEP_Y = 2'd1;
    localparam logic [1:0] STEP_Z = 2'd2;
    localparam logic [1:0] STEP_R = 2'd3;

    // Control registers.
    logic [2:0]        state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  box_reg, box_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Datapath registers.
    logic [POS_W-1:0]  qx_reg, qx_next;
    logic [POS_W-1:0]  qy_reg, qy_next;
    logic [POS_W-1:0]  qz_reg, qz_next;
    logic [POS_W-1:0]  d_reg, d_next;
    logic [POS_W-1:0]  t_reg, t_next;
    logic [SQ_W-1:0]   prod_reg, prod_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              res_found_reg, res_found_next;
    logic              res_status_reg, res_status_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic [MASS_W-1:0] res_mass_reg, res_mass_next;

    // Sphere table.
    sphere_t           mem [MAX_SPHERES];
    sphere_t           ent_reg;
    sphere_t           in_entry;
    logic              mem_we;

    logic              in_fire;
    logic              table_full;
    logic              last_entry;
    logic [POS_W-1:0]  p_sel;
    logic [POS_W-1:0]  s_sel;
    logic [POS_W-1:0]  wrap_term;
    logic [31:0]       scan_wide;

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_fire    = s_tvalid && s_tready;
    assign in_entry   = sphere_t'(s_tdata[SPHERE_W-1:0]);
    assign table_full = (count_reg == CNT_W'(MAX_SPHERES));
    assign last_entry = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign scan_wide  = 32'(scan_idx_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_mass_reg, res_index_reg};
    assign m_tuser  = {res_status_reg, res_found_reg};

    // Pick the query and stored coordinate of the current axis.
    always_comb
    begin
        case (step_reg)
            STEP_X:
            begin
                p_sel = qx_reg;
                s_sel = ent_reg.x;
            end
            STEP_Y:
            begin
                p_sel = qy_reg;
                s_sel = ent_reg.y;
            end
            STEP_Z:
            begin
                p_sel = qz_reg;
                s_sel = ent_reg.z;
            end
            default:
            begin
                p_sel = '0;
                s_sel = '0;
            end
        endcase
    end

    // The wrapped distance saturates at zero when the box is not longer than d.
    assign wrap_term = (box_reg > d_reg) ? (box_reg - d_reg) : '0;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        scan_idx_next   = scan_idx_reg;
        count_next      = count_reg;
        box_next        = box_reg;
        m_tvalid_next   = m_tvalid_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        qz_next         = qz_reg;
        d_next          = d_reg;
        t_next          = t_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_mass_next   = res_mass_reg;
        mem_we          = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            box_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_found_next  = 1'b0;
                    res_status_next = 1'b0;
                    res_index_next  = '0;
                    res_mass_next   = '0;
                    m_tvalid_next   = 1'b1;
                    case (s_tuser)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (table_full)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            qx_next = in_entry.x;
                            qy_next = in_entry.y;
                            qz_next = in_entry.z;
                            // An empty table answers at once with no match.
                            if (count_reg != '0)
                            begin
                                m_tvalid_next = 1'b0;
                                scan_idx_next = '0;
                                state_next    = ST_READ;
                            end
                        end
                        default:
                        begin
                            // The unused command only returns an all-zero word.
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                acc_next   = '0;
                step_next  = STEP_X;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                if (step_reg == STEP_R)
                begin
                    t_next     = ent_reg.radius;
                    state_next = ST_MUL;
                end
                else
                begin
                    d_next     = (p_sel > s_sel) ? (p_sel - s_sel) : (s_sel - p_sel);
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                t_next     = (d_reg < wrap_term) ? d_reg : wrap_term;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = SQ_W'(t_reg) * SQ_W'(t_reg);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (step_reg != STEP_R)
                begin
                    acc_next   = acc_reg + ACC_W'(prod_reg);
                    step_next  = step_reg + 2'd1;
                    state_next = ST_DIFF;
                end
                else if (acc_reg < ACC_W'(prod_reg))
                begin
                    res_found_next = 1'b1;
                    res_index_next = scan_wide[INDEX_W-1:0];
                    res_mass_next  = ent_reg.mass;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (last_entry)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    state_next    = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_X;
            scan_idx_reg <= '0;
            count_reg    <= '0;
            box_reg      <= BOX_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            scan_idx_reg <= scan_idx_next;
            count_reg    <= count_next;
            box_reg      <= box_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        qz_reg         <= qz_next;
        d_reg          <= d_next;
        t_reg          <= t_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_mass_reg   <= res_mass_next;
    end

    // Table write on append, registered read at the scan position.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= in_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= mem[scan_idx_reg];
    end

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SPHERES))
        else $error("sphere count exceeds table size");

    // While a query scans, the scan position stays inside the filled part.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (CNT_W'(scan_idx_reg) < count_reg))
        else $error("scan position beyond fill count");

    // A scan never runs while a result still waits in the output register.
    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !m_tvalid_reg)
        else $error("output word pending during a scan");

    // A query on a non-empty table starts a scan in the next cycle.
    a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser == CMD_QUERY) && (count_reg != '0))
        |=> (state_reg == ST_READ))
        else $error("query did not start a table scan");

    // A found result never carries a reject status.
    a_found_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && res_found_reg) |-> !res_status_reg)
        else $error("found and reject status both set");

endmodule

// ===== sim/sphere_search_checker.sv =====
// Checker for the periodic sphere membership search: watches the config, input
// and output channels, keeps its own copy of the sphere table and the box length,
// and compares every output word with the predicted answer. Depends on psms_pkg.

module sphere_search_checker
    import psms_pkg::*;
#(
    parameter int MAX_SPHERES = DEF_MAX_SPHERES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [POS_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]       s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic [OUT_TUSER_W-1:0] m_tuser,
    output int                     fail_count,
    output int                     pending_count
);

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [MASS_W-1:0]  mass;
        logic               status;
    } answer_t;

    sphere_t          stored_spheres [MAX_SPHERES];
    int unsigned      stored_count = 0;
    logic [POS_W-1:0] box_len = BOX_RESET;
    answer_t          expected_answers [$];
    int unsigned      answer_no = 0;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string field, input logic [MASS_W-1:0] got,
                               input logic [MASS_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("answer %0d: %s is %0h, expected %0h",
                                      answer_no, field, got, want));
    endtask

    // Squared minimum-image distance along one axis; the wrapped term
    // saturates at zero when the gap reaches or exceeds the box.
    function automatic logic [SQ_W-1:0] axis_square(input logic [POS_W-1:0] a,
                                                    input logic [POS_W-1:0] b);
        logic [POS_W-1:0] gap;
        logic [POS_W-1:0] wrapped;
        logic [POS_W-1:0] near;
        logic [SQ_W-1:0]  wide;
        gap     = (a > b) ? a - b : b - a;
        wrapped = (box_len > gap) ? box_len - gap : '0;
        near    = (gap < wrapped) ? gap : wrapped;
        wide    = SQ_W'(near);
        return wide * wide;
    endfunction

    // Applies one input word to the table and returns the answer it causes.
    function automatic answer_t answer_word(input logic [CMD_W-1:0] cmd, input sphere_t w);
        answer_t          ans;
        logic [ACC_W-1:0] span_sq;
        logic [SQ_W-1:0]  reach;
        ans = '0;
        case (cmd)
            CMD_CLEAR:
                stored_count = 0;
            CMD_APPEND:
                if (stored_count < MAX_SPHERES)
                begin
                    stored_spheres[stored_count] = w;
                    stored_count++;
                end
                else
                    ans.status = 1'b1;
            CMD_QUERY:
                for (int j = 0; j < stored_count; j++)
                begin
                    span_sq = ACC_W'(axis_square(w.x, stored_spheres[j].x))
                            + ACC_W'(axis_square(w.y, stored_spheres[j].y))
                            + ACC_W'(axis_square(w.z, stored_spheres[j].z));
                    reach = SQ_W'(stored_spheres[j].radius) * SQ_W'(stored_spheres[j].radius);
                    if (span_sq < ACC_W'(reach))
                    begin
                        ans.found = 1'b1;
                        ans.index = INDEX_W'(j);
                        ans.mass  = stored_spheres[j].mass;
                        break;
                    end
                end
            default:
                ;
        endcase
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            box_len      = BOX_RESET;
            stored_count = 0;
            expected_answers.delete();
            pending_count <= 0;
        end
        else
        begin
            // The output word is compared before a word accepted at the same
            // edge is queued; that word's answer can only come later.
            if (m_tvalid && m_tready)
            begin
                answer_no++;
                got.found  = m_tuser[0];
                got.status = m_tuser[1];
                got.index  = m_tdata[INDEX_W-1:0];
                got.mass   = m_tdata[INDEX_W +: MASS_W];
                if (expected_answers.size() == 0)
                    report_mismatch($sformatf("answer %0d arrived with none expected",
                                              answer_no));
                else
                begin
                    want = expected_answers.pop_front();
                    check_field("found", MASS_W'(got.found), MASS_W'(want.found));
                    check_field("match_index", MASS_W'(got.index), MASS_W'(want.index));
                    check_field("match_mass", got.mass, want.mass);
                    check_field("status", MASS_W'(got.status), MASS_W'(want.status));
                end
            end
            if (s_tvalid && s_tready)
                expected_answers.push_back(answer_word(s_tuser,
                                                       sphere_t'(s_tdata[SPHERE_W-1:0])));
            if (cfg_valid && cfg_ready)
                box_len = cfg_data;
            pending_count <= expected_answers.size();
        end
    end

endmodule

// ===== sim/periodic_sphere_membership_search_test.sv =====
// Testbench top for the periodic sphere membership search: clock, reset, input
// words, config writes, output backpressure and the verdict.
// Depends on psms_pkg, the block and sphere_search_checker.

module periodic_sphere_membership_search_test;

    import psms_pkg::*;

    localparam int MAX_SPHERES = DEF_MAX_SPHERES;

    // The command code the block leaves unused; it must answer with all zeros.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One unit in the 16-fraction-bit coordinate format.
    localparam logic [POS_W-1:0] UNIT = 23'd65536;

    localparam int PHASE_WORDS       = 110;
    localparam int SINK_HOLD_CYCLES  = 300;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [POS_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // From bit 0 up: pos_x, pos_y, pos_z, radius, mass_tag, zero padding.
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    // cmd.
    logic [CMD_W-1:0]       s_tuser   = CMD_CLEAR;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // From bit 0 up: match_index, match_mass, zero padding.
    logic [OUT_TDATA_W-1:0] m_tdata;
    // From bit 0 up: found, status.
    logic [OUT_TUSER_W-1:0] m_tuser;

    int fail_count;
    int pending_count;

    // Stimulus-side view of the box and of the spheres appended since the last
    // clear; used only to aim queries at spheres, never to predict answers.
    logic [POS_W-1:0] box_now     = BOX_RESET;
    sphere_t          placed [$];
    bit               sender_calm = 1'b0;
    logic             sink_hold   = 1'b0;
    event             hold_kick;

    always #5 clk = ~clk;

    periodic_sphere_membership_search #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sphere_search_checker #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Output backpressure. The sink alternates between calm stretches, ready
    // unless held off, and busy ones with short stalls and the odd long one.
    initial
    begin : result_sink
        int stall_left;
        int mode_left;
        int roll;
        bit calm;
        stall_left = 0;
        mode_left  = 0;
        calm       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 400);
            end
            else
                mode_left--;
            roll = $urandom_range(0, 99);
            if (sink_hold)
                m_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (calm || roll >= 30)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                stall_left = (roll < 3) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            end
        end
    end

    // A long hold-off of the sink, counted here in cycles. The sender keeps
    // offering words meanwhile, so the result register fills and s_tready drops.
    initial
    begin : sink_hold_ctl
        forever
        begin
            @(hold_kick);
            @(posedge clk);
            sink_hold <= 1'b1;
            repeat (SINK_HOLD_CYCLES) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    // Offers one word and returns at the edge that accepts it. The valid stays
    // high so that the next word can follow back to back.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                             input logic [POS_W-1:0] r, input logic [MASS_W-1:0] mass);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_TDATA_W'({mass, r, z, y, x});
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Random idle time between words: mostly none, sometimes a few cycles,
    // rarely a long pause. Calm stretches send back to back.
    task automatic sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_calm || roll < 55)
            return;
        s_tvalid <= 1'b0;
        repeat ((roll < 94) ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
    endtask

    // Stops sending and waits until every expected answer has come back.
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    task automatic write_box(input logic [POS_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        box_now = len;
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    function automatic logic [MASS_W-1:0] rand_mass();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        return $urandom;
    endfunction

    // Coordinates mostly fall inside the box, some sit on its edges and some
    // anywhere in the field, which drives the saturated wrap term.
    function automatic logic [POS_W-1:0] rand_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return POS_W'($urandom_range(0, box_now - 1));
        if (roll < 80)
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return box_now - 1'b1;
                default: return box_now;
            endcase
        return rand_pos();
    endfunction

    function automatic logic [POS_W-1:0] rand_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 12)
            return '1;
        if (roll < 82)
            return POS_W'($urandom_range(1, (box_now >> 3) + 1));
        if (roll < 95)
            return POS_W'($urandom_range(0, box_now >> 1));
        return rand_pos();
    endfunction

    // A coordinate near a sphere centre on one axis, either directly or through
    // a periodic image one box length away.
    function automatic logic [POS_W-1:0] near_axis(input logic [POS_W-1:0] c,
                                                   input logic [POS_W-1:0] r);
        logic [POS_W-1:0] off;
        off = POS_W'($urandom_range(0, r));
        case ($urandom_range(0, 5))
            0, 1:    return c + off;
            2, 3:    return c - off;
            4:       return c + box_now - off;
            default: return c - box_now + off;
        endcase
    endfunction

    // Hand-picked words: empty table, the unused command, the strict radius
    // boundary, a hit found only through the saturated wrap, a hit through the
    // periodic image, a zero radius, and clear.
    task automatic run_directed();
        send_word(CMD_QUERY, '0, '0, '0, '0, '0);
        send_word(CMD_UNUSED, '1, '1, '1, '1, '1);
        send_word(CMD_APPEND, '0, '0, '0, UNIT, '1);
        send_word(CMD_APPEND, '1, '1, '1, '1, '0);
        send_word(CMD_QUERY, '0, '0, '0, '0, '0);
        // On the surface of the first sphere: not inside it, so the second
        // sphere, whose centre lies beyond the box, catches it.
        send_word(CMD_QUERY, UNIT, '0, '0, '1, '1);
        // Half a unit from the first sphere across the periodic boundary.
        send_word(CMD_QUERY, BOX_RESET - (UNIT >> 1), '0, '0, '0, '0);
        send_word(CMD_CLEAR, '1, '1, '1, '1, '1);
        send_word(CMD_QUERY, '0, '0, '0, '0, '0);
        send_word(CMD_APPEND, UNIT * 60, UNIT * 60, UNIT * 60, '0, 32'h1234_5678);
        send_word(CMD_QUERY, UNIT * 60, UNIT * 60, UNIT * 60, '0, '0);
        send_word(CMD_APPEND, UNIT, UNIT * 119, UNIT * 60, UNIT * 2, 32'hA5A5_A5A5);
        send_word(CMD_QUERY, '0, '0, UNIT * 60, '0, '0);
        // Exactly two units away along x: on the surface, so no match.
        send_word(CMD_QUERY, UNIT * 3, UNIT * 119, UNIT * 60, '0, '0);
    endtask

    // One random phase: mostly appends and queries aimed at stored spheres,
    // with random queries, clears and unused commands mixed in.
    task automatic run_phase(input int words, input bit squeeze);
        int      sent;
        int      roll;
        sphere_t pick;
        sphere_t fresh;
        sent = 0;
        send_word(CMD_CLEAR, rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_mass());
        placed.delete();
        sent++;
        if (squeeze)
            -> hold_kick;
        while (sent < words)
        begin
            if (sent % 40 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                send_word(CMD_CLEAR, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                          rand_mass());
                placed.delete();
                sent++;
            end
            else if (roll < 6)
                send_word(CMD_UNUSED, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                          rand_mass());
            else if (roll < 10)
            begin
                send_word(CMD_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_pos(),
                          rand_mass());
                sent++;
            end
            else if (placed.size() == 0 || (roll < 40 && placed.size() < 48))
            begin
                fresh.x      = rand_coord();
                fresh.y      = rand_coord();
                fresh.z      = rand_coord();
                fresh.radius = rand_radius();
                fresh.mass   = rand_mass();
                send_word(CMD_APPEND, fresh.x, fresh.y, fresh.z, fresh.radius, fresh.mass);
                placed.push_back(fresh);
                sent++;
            end
            else if (roll < 85)
            begin
                pick = placed[$urandom_range(0, placed.size() - 1)];
                send_word(CMD_QUERY, near_axis(pick.x, pick.radius),
                          near_axis(pick.y, pick.radius), near_axis(pick.z, pick.radius),
                          rand_pos(), rand_mass());
                sent++;
            end
            else
            begin
                send_word(CMD_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_pos(),
                          rand_mass());
                sent++;
            end
            sender_gap();
        end
        sender_calm = 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of the box first, then the smallest box, where every
        // nonzero gap saturates, the largest, a random one, and the reset value again.
        run_directed();
        drain_answers();
        run_phase(PHASE_WORDS, 1'b0);
        drain_answers();
        write_box(POS_W'(1));
        run_phase(PHASE_WORDS, 1'b1);
        drain_answers();
        write_box('1);
        run_phase(PHASE_WORDS, 1'b0);
        drain_answers();
        write_box(POS_W'($urandom_range(2, 8388606)));
        run_phase(PHASE_WORDS, 1'b1);
        drain_answers();
        write_box(BOX_RESET);
        run_phase(PHASE_WORDS, 1'b0);

        drain_answers();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Far beyond the slowest correct run, long scans and long stalls included.
    initial
    begin : watchdog
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
